/* rtl/core/gdbd_pkg.sv */
// Shared types, constants and calendar tables for the Gregorian day-count core.
package gdbd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;

  localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd9999;

  // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam int          DIV100_PROD_W = YEAR_W + 13;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_END_BEFORE = 2'd1,
    STATUS_INVALID    = 2'd2
  } status_t;

  // Length of a month; codes outside 1..12 are rejected elsewhere.
  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    begin
      unique case (m)
        4'd2:                  len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        default:               len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // Days in the year before the first of month m (common year).
  function automatic logic [8:0] days_before_month(logic [MONTH_W-1:0] m);
    logic [8:0] n;
    begin
      unique case (m)
        4'd1:    n = 9'd0;
        4'd2:    n = 9'd31;
        4'd3:    n = 9'd59;
        4'd4:    n = 9'd90;
        4'd5:    n = 9'd120;
        4'd6:    n = 9'd151;
        4'd7:    n = 9'd181;
        4'd8:    n = 9'd212;
        4'd9:    n = 9'd243;
        4'd10:   n = 9'd273;
        4'd11:   n = 9'd304;
        4'd12:   n = 9'd334;
        default: n = 9'd0;
      endcase
      return n;
    end
  endfunction

endpackage

/* rtl/core/gregorian_days_between_dates_core.sv */
// Top level: days between two Gregorian dates, five-stage pipeline.
// Throughput: one transaction per cycle; busy stays low, start is never refused.
// Depth is set by the day-number path (divide by 100, leap/month, year sum, day add).
// Reset (rst_n low, synchronous) clears every in-flight valid bit; no result
// leaves for a transaction accepted before reset. The receiver cannot stall.
module gregorian_days_between_dates_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gdbd_pkg::YEAR_W-1:0]   in_start_year,
  input  logic [gdbd_pkg::MONTH_W-1:0]  in_start_month,
  input  logic [gdbd_pkg::DAY_W-1:0]    in_start_day,
  input  logic [gdbd_pkg::YEAR_W-1:0]   in_end_year,
  input  logic [gdbd_pkg::MONTH_W-1:0]  in_end_month,
  input  logic [gdbd_pkg::DAY_W-1:0]    in_end_day,
  input  logic                          in_include_end,
  output logic                          out_valid,
  output logic [gdbd_pkg::COUNT_W-1:0]  out_day_count,
  output logic [1:0]                    out_status
);

  localparam int CONV_STAGES = 4;

  // The pipeline never backs up, so a transaction is accepted on every start.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Convert both dates to serial day numbers in parallel.
  logic [gdbd_pkg::COUNT_W-1:0] dn_a;
  logic [gdbd_pkg::COUNT_W-1:0] dn_b;
  logic                         ok_a;
  logic                         ok_b;

  gdbd_daynum u_conv_start (
    .clk     (clk),
    .year    (in_start_year),
    .month   (in_start_month),
    .day     (in_start_day),
    .day_num (dn_a),
    .date_ok (ok_a)
  );

  gdbd_daynum u_conv_end (
    .clk     (clk),
    .year    (in_end_year),
    .month   (in_end_month),
    .day     (in_end_day),
    .day_num (dn_b),
    .date_ok (ok_b)
  );

  // Carry valid and the include-end flag alongside the converter stages.
  logic [CONV_STAGES-1:0] vld_r;
  logic [CONV_STAGES-1:0] vld_nxt;
  logic [CONV_STAGES-1:0] inc_r;

  assign vld_nxt = {vld_r[CONV_STAGES-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inc_r <= {inc_r[CONV_STAGES-2:0], in_include_end};
  end

  // Final stage: error precedence is invalid date, then end before start.
  logic [gdbd_pkg::COUNT_W-1:0] count_nxt;
  gdbd_pkg::status_t            status_nxt;

  always_comb begin
    if (!(ok_a && ok_b)) begin
      count_nxt  = '0;
      status_nxt = gdbd_pkg::STATUS_INVALID;
    end else if (dn_b < dn_a) begin
      count_nxt  = '0;
      status_nxt = gdbd_pkg::STATUS_END_BEFORE;
    end else begin
      count_nxt  = dn_b - dn_a + gdbd_pkg::COUNT_W'(inc_r[CONV_STAGES-1]);
      status_nxt = gdbd_pkg::STATUS_OK;
    end
  end

  logic                         out_valid_r;
  logic [gdbd_pkg::COUNT_W-1:0] out_day_count_r;
  gdbd_pkg::status_t            out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[CONV_STAGES-1];
    end
  end

  // Hold payload registers without reset; the strobe qualifies them.
  always_ff @(posedge clk) begin
    out_day_count_r <= count_nxt;
    out_status_r    <= status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_day_count = out_day_count_r;
  assign out_status    = out_status_r;

  // Every accepted transaction yields a result on out_valid.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("accepted transaction produced no result");

  // No result appears without a matching transaction.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result without accepted transaction");

  // Error results carry a zero count.
  a_error_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != gdbd_pkg::STATUS_OK) |-> (out_day_count == '0))
    else $error("error status with nonzero count");

  // A good result with the end day counted is never zero.
  a_inclusive_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == gdbd_pkg::STATUS_OK && $past(in_include_end, 5))
      |-> (out_day_count != '0))
    else $error("inclusive count is zero");

endmodule

/* rtl/core/gdbd_daynum.sv */
// Four-stage pipeline: date check and serial day number (0 for 0000-01-01).
module gdbd_daynum (
  input  logic                          clk,
  input  logic [gdbd_pkg::YEAR_W-1:0]   year,
  input  logic [gdbd_pkg::MONTH_W-1:0]  month,
  input  logic [gdbd_pkg::DAY_W-1:0]    day,
  output logic [gdbd_pkg::COUNT_W-1:0]  day_num,
  output logic                          date_ok
);

  // stage 1: register date, start the divide by 100
  logic [gdbd_pkg::YEAR_W-1:0]        y1_r;
  logic [gdbd_pkg::MONTH_W-1:0]       m1_r;
  logic [gdbd_pkg::DAY_W-1:0]         d1_r;
  logic [gdbd_pkg::DIV100_PROD_W-1:0] prod1_r;
  logic                               fmt1_r;

  always_ff @(posedge clk) begin
    y1_r    <= year;
    m1_r    <= month;
    d1_r    <= day;
    prod1_r <= gdbd_pkg::DIV100_PROD_W'(year) * gdbd_pkg::DIV100_PROD_W'(gdbd_pkg::DIV100_MUL);
    fmt1_r  <= (year <= gdbd_pkg::YEAR_LIMIT) && (month != '0) &&
               (month <= gdbd_pkg::MONTH_DEC) && (day != '0);
  end

  // stage 2: century quotient, leap flag, month offset
  logic [7:0]                  q100;
  logic [6:0]                  r100;
  logic                        leap;
  logic [gdbd_pkg::DAY_W-1:0]  mlen;
  logic [7:0]                  c100_nxt;
  logic [8:0]                  rest_nxt;
  logic                        ok2_nxt;

  always_comb begin
    q100     = prod1_r[gdbd_pkg::DIV100_SHIFT +: 8];
    r100     = 7'(y1_r - gdbd_pkg::YEAR_W'(q100) * 14'd100);
    leap     = ((y1_r[1:0] == 2'd0) && (r100 != '0)) ||
               ((r100 == '0) && (q100[1:0] == 2'd0));
    mlen     = gdbd_pkg::month_len(m1_r, leap);
    ok2_nxt  = fmt1_r && (d1_r <= mlen);
    c100_nxt = q100 + 8'(r100 != '0);
    rest_nxt = gdbd_pkg::days_before_month(m1_r) +
               9'((m1_r > gdbd_pkg::MONTH_FEB) && leap) + 9'(d1_r) - 9'd1;
  end

  logic [gdbd_pkg::YEAR_W-1:0] y2_r;
  logic [7:0]                  c100_r;
  logic [8:0]                  rest2_r;
  logic                        ok2_r;

  always_ff @(posedge clk) begin
    y2_r    <= y1_r;
    c100_r  <= c100_nxt;
    rest2_r <= rest_nxt;
    ok2_r   <= ok2_nxt;
  end

  // stage 3: days before January 1 of the year
  logic [gdbd_pkg::COUNT_W-1:0] yn_nxt;
  logic [14:0]                  y_p3;
  logic [8:0]                   c_p3;

  always_comb begin
    y_p3   = 15'(y2_r) + 15'd3;
    c_p3   = 9'(c100_r) + 9'd3;
    yn_nxt = gdbd_pkg::COUNT_W'(y2_r) * 22'd365 + 22'(y_p3[14:2]) -
             22'(c100_r) + 22'(c_p3[8:2]);
  end

  logic [gdbd_pkg::COUNT_W-1:0] yn3_r;
  logic [8:0]                   rest3_r;
  logic                         ok3_r;

  always_ff @(posedge clk) begin
    yn3_r   <= yn_nxt;
    rest3_r <= rest2_r;
    ok3_r   <= ok2_r;
  end

  // stage 4: add the day of year
  logic [gdbd_pkg::COUNT_W-1:0] dn4_r;
  logic                         ok4_r;

  always_ff @(posedge clk) begin
    dn4_r <= yn3_r + gdbd_pkg::COUNT_W'(rest3_r);
    ok4_r <= ok3_r;
  end

  assign day_num = dn4_r;
  assign date_ok = ok4_r;

endmodule

/* bench/tb_gregorian_days_between_dates_core.sv */
// Self-checking bench for the Gregorian day-count core: stimulus, prediction and scoreboard.
module tb_gregorian_days_between_dates_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transaction on either side before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  // Cycles to keep watching the result port once nothing is expected.
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS = 267;

  typedef struct {
    logic [gdbd_pkg::YEAR_W-1:0]  s_year;
    logic [gdbd_pkg::MONTH_W-1:0] s_month;
    logic [gdbd_pkg::DAY_W-1:0]   s_day;
    logic [gdbd_pkg::YEAR_W-1:0]  e_year;
    logic [gdbd_pkg::MONTH_W-1:0] e_month;
    logic [gdbd_pkg::DAY_W-1:0]   e_day;
    logic                         incl;
  } date_pair_t;

  typedef struct {
    logic [gdbd_pkg::COUNT_W-1:0] count;
    gdbd_pkg::status_t            status;
  } day_span_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [gdbd_pkg::YEAR_W-1:0]  in_start_year  = '0;
  logic [gdbd_pkg::MONTH_W-1:0] in_start_month = '0;
  logic [gdbd_pkg::DAY_W-1:0]   in_start_day   = '0;
  logic [gdbd_pkg::YEAR_W-1:0]  in_end_year    = '0;
  logic [gdbd_pkg::MONTH_W-1:0] in_end_month   = '0;
  logic [gdbd_pkg::DAY_W-1:0]   in_end_day     = '0;
  logic                         in_include_end = 1'b0;
  logic                         out_valid;
  logic [gdbd_pkg::COUNT_W-1:0] out_day_count;
  logic [1:0]                   out_status;

  date_pair_t pending_pairs[$];
  day_span_t  span_expect_q[$];
  logic       in_taken = 1'b0;
  int         send_idle_pct = 17;
  int         fail_count = 0;
  int         hang_cycles = 0;

  gregorian_days_between_dates_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_start_year (in_start_year),
    .in_start_month(in_start_month),
    .in_start_day  (in_start_day),
    .in_end_year   (in_end_year),
    .in_end_month  (in_end_month),
    .in_end_day    (in_end_day),
    .in_include_end(in_include_end),
    .out_valid     (out_valid),
    .out_day_count (out_day_count),
    .out_status    (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Leap year: every 4th year, except centuries, except every 4th century.
  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  // Only meaningful for months 1..12.
  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    if (m == gdbd_pkg::MONTH_FEB) begin
      return leap_year(y) ? 29 : 28;
    end
    case (m)
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
    if (y > gdbd_pkg::YEAR_LIMIT || m < 1 || m > gdbd_pkg::MONTH_DEC || d == 0) begin
      return 1'b0;
    end
    return d <= month_days(y, m);
  endfunction

  // Days since 0000-01-01 (which is day 0); valid dates only.
  function automatic int unsigned serial_day(int unsigned y, int unsigned m, int unsigned d);
    int unsigned n;
    int unsigned k;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (k = 1; k < m; k++) begin
      n += month_days(y, k);
    end
    return n + d - 1;
  endfunction

  // Expected count and status for one date pair; an invalid date wins over a
  // reversed pair.
  function automatic day_span_t predict_span(date_pair_t p);
    day_span_t   r;
    int unsigned from_day;
    int unsigned to_day;
    r.count  = '0;
    r.status = gdbd_pkg::STATUS_OK;
    if (!date_ok(p.s_year, p.s_month, p.s_day) || !date_ok(p.e_year, p.e_month, p.e_day)) begin
      r.status = gdbd_pkg::STATUS_INVALID;
    end else begin
      from_day = serial_day(p.s_year, p.s_month, p.s_day);
      to_day   = serial_day(p.e_year, p.e_month, p.e_day);
      if (to_day < from_day) begin
        r.status = gdbd_pkg::STATUS_END_BEFORE;
      end else begin
        r.count = gdbd_pkg::COUNT_W'(to_day - from_day + p.incl);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  task automatic add_pair(int unsigned sy, int unsigned sm, int unsigned sd,
                          int unsigned ey, int unsigned em, int unsigned ed,
                          int unsigned incl);
    date_pair_t p;
    p.s_year  = gdbd_pkg::YEAR_W'(sy);
    p.s_month = gdbd_pkg::MONTH_W'(sm);
    p.s_day   = gdbd_pkg::DAY_W'(sd);
    p.e_year  = gdbd_pkg::YEAR_W'(ey);
    p.e_month = gdbd_pkg::MONTH_W'(em);
    p.e_day   = gdbd_pkg::DAY_W'(ed);
    p.incl    = incl[0];
    pending_pairs.push_back(p);
  endtask

  // Valid date, biased toward century and leap boundaries and month ends.
  task automatic pick_date(output int unsigned y, output int unsigned m, output int unsigned d);
    int unsigned corner_years[14] = '{0, 1, 4, 100, 400, 1600, 1700, 1800,
                                      1900, 2000, 2100, 2400, 9996, 9999};
    if ($urandom_range(99) < 20) begin
      y = corner_years[$urandom_range(13)];
    end else begin
      y = $urandom_range(gdbd_pkg::YEAR_LIMIT);
    end
    m = $urandom_range(gdbd_pkg::MONTH_DEC, 1);
    if ($urandom_range(99) < 25) begin
      d = month_days(y, m);
    end else begin
      d = $urandom_range(month_days(y, m), 1);
    end
  endtask

  // Break one field of a valid date so that the date becomes invalid.
  task automatic spoil_date(inout int unsigned y, inout int unsigned m, inout int unsigned d);
    int unsigned month_end;
    month_end = month_days(y, m);
    case ($urandom_range(3))
      0: d = 0;
      1: d = (month_end < 31) ? $urandom_range(31, month_end + 1) : 0;
      2: m = ($urandom_range(1) == 0) ? 0 : $urandom_range(15, gdbd_pkg::MONTH_DEC + 1);
      default: y = $urandom_range(16383, gdbd_pkg::YEAR_LIMIT + 1);
    endcase
  endtask

  task automatic add_random_pair();
    int unsigned kind;
    int unsigned sy, sm, sd, ey, em, ed;
    int unsigned ty, tm, td;
    kind = $urandom_range(99);
    pick_date(sy, sm, sd);
    pick_date(ey, em, ed);
    if (kind < 12) begin
      // raw noise over the full port widths
      sy = $urandom_range(16383);
      sm = $urandom_range(15);
      sd = $urandom_range(31);
      ey = $urandom_range(16383);
      em = $urandom_range(15);
      ed = $urandom_range(31);
    end else if (kind < 24) begin
      if ($urandom_range(1) == 0) begin
        spoil_date(sy, sm, sd);
      end else begin
        spoil_date(ey, em, ed);
      end
    end else begin
      // well-formed pair: keep the end near the start much of the time
      case ($urandom_range(2))
        0: begin
          ey = sy;
          ed = (em == gdbd_pkg::MONTH_FEB && !leap_year(ey) && ed > 28) ? 28 : ed;
        end
        1: begin
          ey = sy;
          em = sm;
          ed = $urandom_range(month_days(ey, em), 1);
        end
        default: ;
      endcase
      // order most pairs; the rest stay reversed when they happen to be
      if ($urandom_range(99) < 85 && serial_day(ey, em, ed) < serial_day(sy, sm, sd)) begin
        ty = sy; tm = sm; td = sd;
        sy = ey; sm = em; sd = ed;
        ey = ty; em = tm; ed = td;
      end
    end
    add_pair(sy, sm, sd, ey, em, ed, $urandom_range(1));
  endtask

  task automatic wait_sent();
    while (pending_pairs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge; hold the item until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start          <= 1'b1;
        in_start_year  <= pending_pairs[0].s_year;
        in_start_month <= pending_pairs[0].s_month;
        in_start_day   <= pending_pairs[0].s_day;
        in_end_year    <= pending_pairs[0].e_year;
        in_end_month   <= pending_pairs[0].e_month;
        in_end_day     <= pending_pairs[0].e_day;
        in_include_end <= pending_pairs[0].incl;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on the rising edge, check any result first, then record the
  // transaction taken at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    day_span_t  want;
    date_pair_t seen;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (span_expect_q.size() == 0) begin
          $error("result with no transaction outstanding: day_count %0d status %0d",
                 out_day_count, out_status);
          fail_count++;
        end else begin
          want = span_expect_q.pop_front();
          if (out_day_count !== want.count) begin
            $error("day_count: expected %0d, got %0d", want.count, out_day_count);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        seen.s_year  = in_start_year;
        seen.s_month = in_start_month;
        seen.s_day   = in_start_day;
        seen.e_year  = in_end_year;
        seen.e_month = in_end_month;
        seen.e_day   = in_end_day;
        seen.incl    = in_include_end;
        span_expect_q.push_back(predict_span(seen));
        if (pending_pairs.size() != 0) begin
          void'(pending_pairs.pop_front());
        end
      end
      in_taken <= start && !busy;
    end
  end

  // Watchdog: abort when neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        hang_cycles = 0;
      end else begin
        hang_cycles++;
      end
      if (hang_cycles >= HANG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, leap rules, invalid dates, reversed pairs.
    send_idle_pct = 17;
    add_pair(0, 1, 1, 0, 1, 1, 0);               // equal dates, count 0
    add_pair(0, 1, 1, 0, 1, 1, 1);               // equal dates, count 1
    add_pair(0, 1, 1, 9999, 12, 31, 1);          // widest span
    add_pair(0, 2, 29, 0, 3, 1, 0);              // year zero is leap
    add_pair(1900, 2, 29, 1900, 3, 1, 0);        // plain century is not leap
    add_pair(2000, 2, 29, 2000, 3, 1, 1);        // fourth century is leap
    add_pair(2100, 2, 28, 2100, 3, 1, 0);
    add_pair(1600, 2, 29, 2400, 2, 29, 1);
    add_pair(1999, 12, 31, 2000, 1, 1, 1);
    add_pair(2024, 1, 31, 2024, 12, 31, 0);
    add_pair(2020, 0, 10, 2021, 1, 1, 0);        // month zero
    add_pair(2020, 1, 10, 2021, 13, 1, 1);       // month past December
    add_pair(2020, 15, 31, 2021, 1, 1, 0);       // all-ones month and day
    add_pair(2020, 5, 0, 2021, 1, 1, 0);         // day zero
    add_pair(2020, 4, 31, 2021, 1, 1, 1);        // day past a short month
    add_pair(10000, 1, 1, 10000, 1, 2, 0);       // year above the limit
    add_pair(0, 1, 1, 16383, 12, 31, 1);         // all-ones year
    add_pair(2020, 3, 2, 2020, 3, 1, 1);         // end one day early
    add_pair(9999, 12, 31, 0, 1, 1, 0);          // fully reversed
    add_pair(2020, 3, 2, 2020, 2, 30, 0);        // invalid and reversed: invalid wins
    add_pair(9999, 12, 31, 9999, 12, 31, 1);
    repeat (PHASE_ITEMS) add_random_pair();
    wait_sent();

    send_idle_pct = 47;
    repeat (PHASE_ITEMS) add_random_pair();
    wait_sent();

    send_idle_pct = 0;
    repeat (PHASE_ITEMS) add_random_pair();
    wait_sent();

    // Drain, then keep watching for stray results.
    while (span_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
